// ===== hdl/bevq_pkg.sv =====
// Shared types and constants for the button event qualifier.
// No dependencies; used by bevq_step and the top level.
`default_nettype none

package bevq_pkg;

  localparam int unsigned WORD_W  = 16;
  localparam int unsigned INDEX_W = 4;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned TICK_W  = 10;
  localparam int unsigned MS_W    = 26;
  localparam int unsigned HOLD_W  = 4;   // covers -2 up to the largest hold-off of 7
  localparam int unsigned CFG_W   = 2;

  typedef logic signed [HOLD_W-1:0] hold_t;

  localparam hold_t HOLD_FLOOR = -4'sd2;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_DOWN     = 2'd1,
    EV_PRESSING = 2'd2,
    EV_UP       = 2'd3
  } event_e;

  typedef enum logic [CFG_W-1:0] {
    CFG_ENABLED    = 2'd0,
    CFG_ACTIVE_LOW = 2'd1,
    CFG_TICK_MS    = 2'd2
  } cfg_index_e;

  // Outcome of one button visit
  typedef struct packed {
    hold_t              hold;
    logic               armed;
    logic [COUNT_W-1:0] count;
    event_e             ev;
    logic               scale;        // held time must be recomputed
    logic [COUNT_W-1:0] scale_count;  // count used for the held time
  } step_t;

endpackage

`default_nettype wire

// ===== hdl/button_event_qualifier.sv =====
// Button event qualifier top level: sequencer, per-button state, shared update unit.
// Depends on bevq_pkg and bevq_step.
//
// Usage: one beat on the s_axis channel carries one tick's raw button word.
// The block then walks button positions 0..BUTTONS-1 and, for each enabled
// one, sends one beat on m_axis: index, event (none/down/pressing/up) and
// held time in ms; tlast marks the highest enabled button of the tick.
// A tick with no enabled button gives no output beat.
// Each position visited passes ST_VISIT (the walk stops after the highest
// enabled button); each enabled button then passes ST_EMIT to load the output
// register, with ST_SCALE before it where the held time is rescaled through
// the single 16x10 multiplier. The next beat is taken in ST_IDLE, and
// s_axis_tready is low in every other state.
// The output register stalls the walk while its beat is not taken, so a
// low m_axis_tready simply pauses the block; nothing is lost.
// Configuration writes (enabled mask, active-low mask, tick_ms) are always
// accepted and must be issued only while idle.
// Reset clears all button state, the masks, and sets tick_ms to 1.
`default_nettype none

module button_event_qualifier #(
  parameter int unsigned BUTTONS       = 16,
  parameter int unsigned HOLDOFF_TICKS = 3
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // config write channel
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [bevq_pkg::CFG_W-1:0]    cfg_index_i,
  input  wire logic [bevq_pkg::WORD_W-1:0]   cfg_data_i,
  // input stream
  input  wire logic                          s_axis_tvalid_i,
  output      logic                          s_axis_tready_o,
  input  wire logic [15:0]                   s_axis_tdata_i,  // [15:0] buttons_word
  // output stream
  output      logic                          m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output      logic [31:0]                   m_axis_tdata_o,  // [3:0] button_index,
                                                              // [5:4] event_res,
                                                              // [31:6] press_ms
  output      logic                          m_axis_tlast_o   // last
);

  localparam int unsigned IW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam logic [bevq_pkg::WORD_W-1:0] LIVE_MASK =
    {bevq_pkg::WORD_W{1'b1}} >> (bevq_pkg::WORD_W - BUTTONS);
  localparam logic [IW-1:0] LAST_IDX = IW'(BUTTONS - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_VISIT = 2'd1;
  localparam logic [1:0] ST_SCALE = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]                          state_q, state_d;
  logic [IW-1:0]                       idx_q, idx_d;
  logic [bevq_pkg::WORD_W-1:0]         word_q;
  logic [bevq_pkg::WORD_W-1:0]         enabled_q, active_low_q;
  logic [bevq_pkg::TICK_W-1:0]         tick_q;
  bevq_pkg::event_e                    ev_q;
  logic [bevq_pkg::COUNT_W-1:0]        mul_op_q;

  bevq_pkg::hold_t                     hold_q  [BUTTONS];
  logic                                armed_q [BUTTONS];
  logic [bevq_pkg::COUNT_W-1:0]        count_q [BUTTONS];
  logic [bevq_pkg::MS_W-1:0]           held_q  [BUTTONS];

  logic                                out_valid_q;
  logic [bevq_pkg::INDEX_W-1:0]        out_index_q;
  bevq_pkg::event_e                    out_ev_q;
  logic [bevq_pkg::MS_W-1:0]           out_ms_q;
  logic                                out_last_q;

  logic [bevq_pkg::WORD_W-1:0]         live;
  logic                                in_beat, out_free, cur_live, cur_key, cur_last;
  logic                                visit_en, scale_en, emit_en;
  bevq_pkg::step_t                     step;
  logic [bevq_pkg::MS_W-1:0]           product;

  assign live      = enabled_q & LIVE_MASK;
  assign in_beat   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign cur_live  = live[idx_q];
  assign cur_key   = word_q[idx_q] ^ active_low_q[idx_q];
  // nothing enabled above the current position
  assign cur_last  = ((live >> idx_q) >> 1) == '0;

  assign visit_en  = (state_q == ST_VISIT) && cur_live;
  assign scale_en  = (state_q == ST_SCALE);
  assign emit_en   = (state_q == ST_EMIT) && out_free;

  assign product   = bevq_pkg::MS_W'(mul_op_q * tick_q);

  bevq_step #(
    .HOLDOFF_TICKS(HOLDOFF_TICKS)
  ) u_step (
    .key_i  (cur_key),
    .hold_i (hold_q[idx_q]),
    .armed_i(armed_q[idx_q]),
    .count_i(count_q[idx_q]),
    .res_o  (step)
  );

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          state_d = ST_VISIT;
          idx_d   = '0;
        end
      end
      ST_VISIT: begin
        if (cur_live) begin
          state_d = step.scale ? ST_SCALE : ST_EMIT;
        end else if (idx_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_SCALE: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          if (cur_last || (idx_q == LAST_IDX)) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_VISIT;
            idx_d   = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      enabled_q    <= '0;
      active_low_q <= '0;
      tick_q       <= bevq_pkg::TICK_W'(1);
      out_valid_q  <= 1'b0;
      for (int i = 0; i < BUTTONS; i++) begin
        hold_q[i]  <= '0;
        armed_q[i] <= 1'b0;
        count_q[i] <= '0;
        held_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          bevq_pkg::CFG_ENABLED:    enabled_q    <= cfg_data_i;
          bevq_pkg::CFG_ACTIVE_LOW: active_low_q <= cfg_data_i;
          bevq_pkg::CFG_TICK_MS:    tick_q       <= cfg_data_i[bevq_pkg::TICK_W-1:0];
          default: ;
        endcase
      end
      if (visit_en) begin
        hold_q[idx_q]  <= step.hold;
        armed_q[idx_q] <= step.armed;
        count_q[idx_q] <= step.count;
      end
      if (scale_en) begin
        held_q[idx_q] <= product;
      end
      if (emit_en) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      word_q <= s_axis_tdata_i;
    end
    if (visit_en) begin
      ev_q     <= step.ev;
      mul_op_q <= step.scale_count;
    end
    if (emit_en) begin
      out_index_q <= bevq_pkg::INDEX_W'(idx_q);
      out_ev_q    <= ev_q;
      out_ms_q    <= held_q[idx_q];
      out_last_q  <= cur_last;
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_ms_q, out_ev_q, out_index_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

// ===== hdl/bevq_step.sv =====
// Per-button update unit, shared by all buttons under the top-level sequencer.
// Depends on bevq_pkg.
`default_nettype none

module bevq_step #(
  parameter int unsigned HOLDOFF_TICKS = 3
) (
  input  wire logic                          key_i,
  input  wire bevq_pkg::hold_t               hold_i,
  input  wire logic                          armed_i,
  input  wire logic [bevq_pkg::COUNT_W-1:0]  count_i,
  output bevq_pkg::step_t                    res_o
);

  logic                          idle_press;
  bevq_pkg::hold_t               hold_dec;
  logic [bevq_pkg::COUNT_W-1:0]  count_inc;

  assign idle_press = key_i && (count_i == '0);
  assign hold_dec   = (idle_press && (hold_i > bevq_pkg::HOLD_FLOOR))
                      ? bevq_pkg::hold_t'(hold_i - bevq_pkg::hold_t'(1)) : hold_i;
  assign count_inc  = (count_i != '1) ? count_i + 1'b1 : count_i;

  always_comb begin
    res_o             = '0;
    res_o.hold        = hold_dec;
    res_o.armed       = armed_i;
    res_o.count       = count_i;
    res_o.ev          = bevq_pkg::EV_NONE;
    res_o.scale       = 1'b0;
    res_o.scale_count = count_inc;
    if (idle_press && (hold_dec <= bevq_pkg::hold_t'(0))) begin
      if (armed_i) begin
        res_o.ev    = bevq_pkg::EV_DOWN;
        res_o.count = bevq_pkg::COUNT_W'(1);
      end else begin
        res_o.armed = 1'b1;
      end
    end else begin
      if (count_i != '0) begin
        res_o.ev    = bevq_pkg::EV_PRESSING;
        res_o.count = count_inc;
        res_o.scale = 1'b1;
      end
      // release after down: held time still takes the final count
      if (!key_i && (count_i != '0)) begin
        res_o.ev    = bevq_pkg::EV_UP;
        res_o.count = '0;
        res_o.hold  = bevq_pkg::hold_t'(HOLDOFF_TICKS);
        res_o.armed = 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bevq_checker.sv =====
// Port-level checks for the button event qualifier, bound to the top level.
// Depends on button_event_qualifier as the bind target.
`default_nettype none

module bevq_checker #(
  parameter int unsigned BUTTONS = 16
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o,
  input wire logic        m_axis_tlast_o
);

  // a stalled output beat keeps its valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output beat dropped while stalled");

  // a stalled output beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output beat changed while stalled");

  // a tick is worked on alone: no second input beat straight after one
  a_one_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while a tick is in progress");

  // reported index is a real button position
  a_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (32'(m_axis_tdata_o[3:0]) < BUTTONS))
    else $error("output index beyond button count");

  // config port never back-pressures
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

endmodule

bind button_event_qualifier bevq_checker #(.BUTTONS(BUTTONS)) u_bevq_checker (.*);

`default_nettype wire
